// ===== src/csls_pkg.sv =====
package csls_pkg;

  localparam int DEPTH_DEF  = 64;

  localparam int OPCODE_W   = 3;
  localparam int POS_W      = 6;
  localparam int COPIES_W   = 7;
  localparam int SYM_W      = 8;
  localparam int STATUS_W   = 2;
  localparam int LEN_W      = 7;

  // Input word: position, copies, symbol from bit 0 up, padded to whole bytes.
  localparam int IN_DATA_W  = 24;
  // Output word: status, length, read symbol from bit 0 up, padded to whole bytes.
  localparam int OUT_DATA_W = 24;

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_PREPEND   = 3'd1,
    OP_TAKE_HEAD = 3'd2,
    OP_TAKE_TAIL = 3'd3,
    OP_INSERT    = 3'd4,
    OP_ERASE     = 3'd5,
    OP_COPIES    = 3'd6,
    OP_READ      = 3'd7
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // The command that every cell of the row is given: hold, insert or delete.
  typedef enum logic [1:0] {
    CK_HOLD = 2'd0,
    CK_INS  = 2'd1,
    CK_DEL  = 2'd2
  } cell_kind_t;

  typedef struct packed {
    cell_kind_t       kind;
    logic [SYM_W-1:0] sym;
  } cell_cmd_t;

endpackage

// ===== src/csls_cell.sv =====
module csls_cell #(
  parameter int IDX_W = 6,
  parameter int INDEX = 0
) (
  input  logic                      clk,
  input  csls_pkg::cell_cmd_t       cmd,
  input  logic [IDX_W-1:0]          at,
  input  logic [IDX_W-1:0]          rd_at,
  input  logic [csls_pkg::SYM_W-1:0] left_sym,
  input  logic [csls_pkg::SYM_W-1:0] right_sym,
  output logic [csls_pkg::SYM_W-1:0] sym_q,
  output logic [csls_pkg::SYM_W-1:0] rd_sym
);
  import csls_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [SYM_W-1:0] sym_r;
  logic [SYM_W-1:0] sym_nxt;

  // An insert moves every cell above the gap one place toward the back and
  // loads the new symbol into the gap; an erase pulls the tail one place forward.
  always_comb begin
    sym_nxt = sym_r;
    case (cmd.kind)
      CK_INS: begin
        if (MY_IDX > at) begin
          sym_nxt = left_sym;
        end else if (MY_IDX == at) begin
          sym_nxt = cmd.sym;
        end
      end
      CK_DEL: begin
        if (MY_IDX >= at) begin
          sym_nxt = right_sym;
        end
      end
      default: begin
        sym_nxt = sym_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
  end

  assign sym_q  = sym_r;
  assign rd_sym = (MY_IDX == rd_at) ? sym_r : '0;

endmodule

// ===== src/char_sequence_list_store.sv =====
// Each result is registered and appears in the cycle after its word is accepted,
// but for the copies insert, whose result appears once its last copy has gone in.
// Throughput: one word per cycle while results are taken, since every insert
// or erase is a single shift of the cell row; a copies insert holds the input
// until its last copy has gone in. Reset (rst_n low, synchronous) empties the
// list and drops the output valid; cell contents are left as they are.
module char_sequence_list_store #(
  parameter int DEPTH = csls_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0 up: position[5:0], copies[12:6], symbol[20:13], zero pad.
  input  logic [csls_pkg::IN_DATA_W-1:0]      in_tdata,
  // Fields from bit 0 up: opcode[2:0].
  input  logic [csls_pkg::OPCODE_W-1:0]       in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0 up: status[1:0], length[8:2], read_symbol[16:9], zero pad.
  output logic [csls_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import csls_pkg::*;

  // Index width into the row, count width able to hold DEPTH itself, and a
  // compare width wide enough for both the count and the copies field.
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > COPIES_W) ? CNT_W : COPIES_W;

  typedef enum logic {
    S_IDLE,
    S_COPY
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [COPIES_W-1:0]  rem_r, rem_nxt;
  logic [IDX_W-1:0]     at_r, at_nxt;
  logic [SYM_W-1:0]     csym_r, csym_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              status_r, status_nxt;
  logic [SYM_W-1:0]     rd_r, rd_nxt;

  // Input word fields.
  opcode_t              opc;
  logic [POS_W-1:0]     pos;
  logic [COPIES_W-1:0]  cps;
  logic [SYM_W-1:0]     sym;

  logic                 acc;
  logic [CW-1:0]        cnt_ext;
  logic [CW-1:0]        pos_ext;
  logic [CW-1:0]        cps_ext;
  logic [CW-1:0]        room_ext;
  logic [CW-1:0]        pos_inc;
  logic                 pos_ok;
  logic                 is_full;
  logic                 is_empty;

  // Command broadcast to the cell row.
  cell_cmd_t            cmd;
  logic [IDX_W-1:0]     cmd_at;
  logic [IDX_W-1:0]     rd_at;

  logic [SYM_W-1:0]     cell_q  [DEPTH];
  logic [SYM_W-1:0]     cell_rd [DEPTH];
  logic [SYM_W-1:0]     rd_any;

  assign opc = opcode_t'(in_tuser);
  assign pos = in_tdata[POS_W-1:0];
  assign cps = in_tdata[POS_W+COPIES_W-1:POS_W];
  assign sym = in_tdata[POS_W+COPIES_W+SYM_W-1:POS_W+COPIES_W];

  // A new word is taken only when idle and the output register is free or
  // being emptied in this same cycle.
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign acc       = in_tvalid && in_tready;

  assign cnt_ext  = CW'(count_r);
  assign pos_ext  = CW'(pos);
  assign cps_ext  = CW'(cps);
  assign room_ext = CW'(DEPTH) - cnt_ext;
  assign pos_inc  = pos_ext + CW'(1);
  assign pos_ok   = pos_ext < cnt_ext;
  assign is_full  = (cnt_ext == CW'(DEPTH));
  assign is_empty = (count_r == '0);
  assign rd_at    = pos_ext[IDX_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    at_nxt        = at_r;
    csym_nxt      = csym_r;
    status_nxt    = status_r;
    rd_nxt        = rd_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.kind      = CK_HOLD;
    cmd.sym       = sym;
    cmd_at        = '0;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          rd_nxt        = '0;
          case (opc)
            OP_APPEND: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                cmd.kind  = CK_INS;
                cmd_at    = count_r[IDX_W-1:0];
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_PREPEND: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                cmd.kind  = CK_INS;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_TAKE_HEAD: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                cmd.kind  = CK_DEL;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            OP_TAKE_TAIL: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                cmd.kind  = CK_DEL;
                cmd_at    = IDX_W'(count_r - CNT_W'(1));
                count_nxt = count_r - CNT_W'(1);
              end
            end
            OP_INSERT: begin
              if (!pos_ok) begin
                status_nxt = ST_RANGE;
              end else if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                cmd.kind  = CK_INS;
                cmd_at    = pos_inc[IDX_W-1:0];
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_ERASE: begin
              if (!pos_ok) begin
                status_nxt = ST_RANGE;
              end else begin
                cmd.kind  = CK_DEL;
                cmd_at    = rd_at;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            OP_COPIES: begin
              if (!pos_ok) begin
                status_nxt = ST_RANGE;
              end else if (cps_ext > room_ext) begin
                status_nxt = ST_FULL;
              end else if (cps != '0) begin
                // The result waits until the last copy has gone in.
                out_valid_nxt = 1'b0;
                state_nxt     = S_COPY;
                rem_nxt       = cps;
                at_nxt        = pos_inc[IDX_W-1:0];
                csym_nxt      = sym;
              end
            end
            OP_READ: begin
              if (!pos_ok) begin
                status_nxt = ST_RANGE;
              end else begin
                rd_nxt = rd_any;
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_COPY: begin
        // Each cycle inserts one copy at the same place; the row shifts the
        // earlier copies back, which leaves the same run of equal symbols.
        cmd.kind  = CK_INS;
        cmd.sym   = csym_r;
        cmd_at    = at_r;
        count_nxt = count_r + CNT_W'(1);
        rem_nxt   = rem_r - COPIES_W'(1);
        if (rem_r == COPIES_W'(1)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rem_r    <= rem_nxt;
    at_r     <= at_nxt;
    csym_r   <= csym_nxt;
    status_r <= status_nxt;
    rd_r     <= rd_nxt;
  end

  // The row of cells: element 0 at the front, each cell fed by its neighbors, zero past either end.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [SYM_W-1:0] left_sym;
    logic [SYM_W-1:0] right_sym;

    if (i == 0) begin : g_first
      assign left_sym = '0;
    end else begin : g_mid_l
      assign left_sym = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_sym = '0;
    end else begin : g_mid_r
      assign right_sym = cell_q[i+1];
    end

    csls_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .at        (cmd_at),
      .rd_at     (rd_at),
      .left_sym  (left_sym),
      .right_sym (right_sym),
      .sym_q     (cell_q[i]),
      .rd_sym    (cell_rd[i])
    );
  end

  // Only the addressed cell drives a nonzero read value.
  always_comb begin
    rd_any = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_any = rd_any | cell_rd[k];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - STATUS_W - LEN_W - SYM_W)'(0),
                       rd_r, cnt_ext[LEN_W-1:0], status_r};

endmodule

// ===== src/csls_checker.sv =====
module csls_checker #(
  parameter int DEPTH = csls_pkg::DEPTH_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [csls_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import csls_pkg::*;

  logic [STATUS_W-1:0] st;
  logic [LEN_W-1:0]    len;
  logic [SYM_W-1:0]    rsym;

  assign st   = out_tdata[STATUS_W-1:0];
  assign len  = out_tdata[STATUS_W+LEN_W-1:STATUS_W];
  assign rsym = out_tdata[STATUS_W+LEN_W+SYM_W-1:STATUS_W+LEN_W];

  // A word is never taken while a result is stuck in the output register.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!out_tvalid || out_tready))
    else $error("word accepted while result stalled");

  // An empty report always comes with a zero length.
  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (st == ST_EMPTY)) |-> (len == '0))
    else $error("empty status with nonzero length");

  // Only a successful read carries a symbol.
  a_rd_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (rsym != '0)) |-> (st == ST_OK))
    else $error("read symbol on a failed operation");

  // A stalled result holds its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind char_sequence_list_store csls_checker #(
  .DEPTH (DEPTH)
) u_csls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
